// File: hdl/wlq_pkg.sv
// Shared types and constants for the worker liveness LRU queue.
// Used by the front end, the command queue, the table engine and the top level.
package wlq_pkg;

  localparam int MAX_WORKERS = 16;
  localparam int ID_W        = 16;
  localparam int CNT_W       = $clog2(MAX_WORKERS + 1);
  localparam int IDX_W       = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int TIME_W      = 32;
  localparam int TICKS_W     = 16;

  localparam logic [TICKS_W-1:0] EXPIRY_RST = 16'd3000;
  localparam logic [TICKS_W-1:0] HB_RST     = 16'd1000;

  localparam logic [2:0] OP_REFRESH = 3'd0;
  localparam logic [2:0] OP_FORWARD = 3'd1;
  localparam logic [2:0] OP_INVALID = 3'd2;
  localparam logic [2:0] OP_REQUEST = 3'd3;
  localparam logic [2:0] OP_TICK    = 3'd4;
  localparam logic [2:0] OP_NOP     = 3'd5;

  typedef struct packed {
    logic [2:0]      op;
    logic [ID_W-1:0] id;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_st_t;

endpackage

// File: hdl/worker_liveness_lru_queue.sv
// Worker liveness LRU queue: front end, command queue, table engine, config registers.
// The table engine's sequencer takes a new item only after it is through with the last one,
// including the append of a stored worker item, the expiry purge and the heartbeat results.
// Reset (rst_n low, synchronous): empty table, time 0, next heartbeat 1000,
// expiry_ticks 3000, heartbeat_ticks 1000.
module worker_liveness_lru_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // worker_id[15:0], control_byte[23:16]
  input  logic [2:0]  in_tuser,   // func[1:0], single_frame[2]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // worker_id_res[15:0]
  output logic [2:0]  out_tuser,  // kind[2:0]
  output logic        out_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import wlq_pkg::*;

  localparam logic REG_EXPIRY = 1'b0;
  localparam logic REG_HBEAT  = 1'b1;

  logic [TICKS_W-1:0] expiry_r, expiry_nxt;
  logic [TICKS_W-1:0] hb_r, hb_nxt;
  logic               cfg_wr;
  fifo_st_t           fifo_st;
  logic               push, pop;
  cmd_t               push_cmd, pop_cmd;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    expiry_nxt = expiry_r;
    hb_nxt     = hb_r;
    if (cfg_wr) begin
      if (paddr[2] == REG_EXPIRY) begin
        expiry_nxt = pwdata[TICKS_W-1:0];
      end else begin
        hb_nxt = pwdata[TICKS_W-1:0];
      end
    end
    prdata = (paddr[2] == REG_HBEAT) ? 32'(hb_r) : 32'(expiry_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expiry_r <= EXPIRY_RST;
      hb_r     <= HB_RST;
    end else begin
      expiry_r <= expiry_nxt;
      hb_r     <= hb_nxt;
    end
  end

  wlq_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .fifo_st   (fifo_st),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  wlq_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .st       (fifo_st)
  );

  wlq_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (!fifo_st.empty),
    .cmd             (pop_cmd),
    .cmd_pop         (pop),
    .expiry_ticks    (expiry_r),
    .heartbeat_ticks (hb_r),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast)
  );

endmodule

// File: hdl/wlq_front.sv
// Input side: accepts items and classifies them into table commands.
// Depends on wlq_pkg; feeds wlq_fifo.
module wlq_front (
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [23:0]          in_tdata,  // worker_id[15:0], control_byte[23:16]
  input  logic [2:0]           in_tuser,  // func[1:0], single_frame[2]
  input  wlq_pkg::fifo_st_t    fifo_st,
  output logic                 push,
  output wlq_pkg::cmd_t        push_cmd
);
  import wlq_pkg::*;

  localparam logic [1:0] FUNC_WORKER  = 2'd0;
  localparam logic [1:0] FUNC_REQUEST = 2'd1;
  localparam logic [1:0] FUNC_TICK    = 2'd2;
  localparam logic [7:0] CTRL_READY   = 8'd1;
  localparam logic [7:0] CTRL_HBEAT   = 8'd2;

  logic [1:0] func;
  logic       single;
  logic [7:0] ctrl;

  assign func   = in_tuser[1:0];
  assign single = in_tuser[2];
  assign ctrl   = in_tdata[23:16];

  assign in_tready = !fifo_st.full;
  assign push      = in_tvalid && !fifo_st.full;

  always_comb begin
    push_cmd.id = in_tdata[ID_W-1:0];
    case (func)
      FUNC_WORKER: begin
        if (!single) begin
          push_cmd.op = OP_FORWARD;
        end else if (ctrl == CTRL_READY || ctrl == CTRL_HBEAT) begin
          push_cmd.op = OP_REFRESH;
        end else begin
          push_cmd.op = OP_INVALID;
        end
      end
      FUNC_REQUEST: push_cmd.op = OP_REQUEST;
      FUNC_TICK:    push_cmd.op = OP_TICK;
      default:      push_cmd.op = OP_NOP;
    endcase
  end

endmodule

// File: hdl/wlq_fifo.sv
// Short command queue between the front end and the table engine.
// Depends on wlq_pkg.
module wlq_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  wlq_pkg::cmd_t      push_cmd,
  input  logic               pop,
  output wlq_pkg::cmd_t      pop_cmd,
  output wlq_pkg::fifo_st_t  st
);
  import wlq_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int LVL_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [LVL_W-1:0] lvl_r, lvl_nxt;
  logic             do_push, do_pop;

  assign st.full  = (lvl_r == LVL_W'(DEPTH));
  assign st.empty = (lvl_r == '0);
  assign do_push  = push && !st.full;
  assign do_pop   = pop && !st.empty;
  assign pop_cmd  = mem_r[rd_r];

  always_comb begin
    wr_nxt  = do_push ? wr_r + PTR_W'(1) : wr_r;
    rd_nxt  = do_pop ? rd_r + PTR_W'(1) : rd_r;
    lvl_nxt = lvl_r;
    if (do_push && !do_pop) begin
      lvl_nxt = lvl_r + LVL_W'(1);
    end else if (do_pop && !do_push) begin
      lvl_nxt = lvl_r - LVL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      lvl_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      lvl_r <= lvl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

endmodule

// File: hdl/wlq_back.sv
// Table engine: ordered worker table, time, heartbeat rounds, expiry purge.
// Depends on wlq_pkg; takes commands from wlq_fifo and drives the result register.
module wlq_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cmd_valid,
  input  wlq_pkg::cmd_t                     cmd,
  output logic                              cmd_pop,
  input  logic [wlq_pkg::TICKS_W-1:0]       expiry_ticks,
  input  logic [wlq_pkg::TICKS_W-1:0]       heartbeat_ticks,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [15:0]                       out_tdata,  // worker_id_res[15:0]
  output logic [2:0]                        out_tuser,  // kind[2:0]
  output logic                              out_tlast
);
  import wlq_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_APPEND = 3'd2;
  localparam logic [2:0] S_HB     = 3'd3;
  localparam logic [2:0] S_PURGE  = 3'd4;

  localparam logic [2:0] K_ASSIGN  = 3'd0;
  localparam logic [2:0] K_HBEAT   = 3'd1;
  localparam logic [2:0] K_FORWARD = 3'd2;
  localparam logic [2:0] K_INVALID = 3'd3;
  localparam logic [2:0] K_NOWORK  = 3'd4;
  localparam logic [2:0] K_FULL    = 3'd5;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WORKERS);

  logic [2:0]        state_r, state_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [ID_W-1:0]   ids_r [MAX_WORKERS];
  logic [ID_W-1:0]   ids_nxt [MAX_WORKERS];
  logic [TIME_W-1:0] exp_r [MAX_WORKERS];
  logic [TIME_W-1:0] exp_nxt [MAX_WORKERS];
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [TIME_W-1:0] nhb_r, nhb_nxt;
  logic [IDX_W-1:0]  hb_idx_r, hb_idx_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic [2:0]        out_kind_r, out_kind_nxt;
  logic [ID_W-1:0]   out_id_r, out_id_nxt;
  logic              out_last_r, out_last_nxt;

  logic [MAX_WORKERS-1:0] match;
  logic                   found;
  logic [IDX_W-1:0]       pos;
  logic                   rm_en;
  logic [IDX_W-1:0]       rm_pos;
  logic                   wr_en;
  logic                   out_free;
  logic                   full;
  logic [CNT_W-1:0]       cnt_m1;
  logic [TIME_W-1:0]      t_inc;
  logic [TIME_W-1:0]      d_hb;
  logic [TIME_W-1:0]      d_exp;
  logic                   head_expired;
  logic                   hb_last;

  assign out_free = !out_vld_r || out_tready;
  assign full     = (cnt_r == CNT_MAX);
  assign cnt_m1   = cnt_r - CNT_W'(1);
  assign t_inc    = time_r + TIME_W'(1);
  assign d_hb     = t_inc - nhb_r;
  assign d_exp    = time_r - exp_r[0];
  assign head_expired = (cnt_r != '0) && !d_exp[TIME_W-1];
  assign hb_last  = (CNT_W'(hb_idx_r) == cnt_m1) ||
                    (hb_idx_r == IDX_W'(MAX_WORKERS - 1));

  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int i = 0; i < MAX_WORKERS; i++) begin
      match[i] = (ids_r[i] == cmd_r.id) && (CNT_W'(i) < cnt_r);
    end
    for (int i = MAX_WORKERS - 1; i >= 0; i--) begin
      if (match[i]) begin
        found = 1'b1;
        pos   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    cnt_nxt      = cnt_r;
    time_nxt     = time_r;
    nhb_nxt      = nhb_r;
    hb_idx_nxt   = hb_idx_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_kind_nxt = out_kind_r;
    out_id_nxt   = out_id_r;
    out_last_nxt = out_last_r;
    rm_en        = 1'b0;
    rm_pos       = '0;
    wr_en        = 1'b0;
    cmd_pop      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop   = 1'b1;
          cmd_nxt   = cmd;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cmd_r.op)
          OP_REFRESH, OP_FORWARD, OP_INVALID: begin
            if (!found && full) begin
              if (out_free) begin
                out_vld_nxt  = 1'b1;
                out_kind_nxt = K_FULL;
                out_id_nxt   = cmd_r.id;
                out_last_nxt = 1'b1;
                state_nxt    = S_PURGE;
              end
            end else begin
              if (found) begin
                rm_en   = 1'b1;
                rm_pos  = pos;
                cnt_nxt = cnt_m1;
              end
              state_nxt = S_APPEND;
            end
          end
          OP_REQUEST: begin
            if (out_free) begin
              out_vld_nxt  = 1'b1;
              out_last_nxt = 1'b1;
              if (cnt_r == '0) begin
                out_kind_nxt = K_NOWORK;
                out_id_nxt   = '0;
              end else begin
                out_kind_nxt = K_ASSIGN;
                out_id_nxt   = ids_r[0];
                rm_en        = 1'b1;
                cnt_nxt      = cnt_m1;
              end
              state_nxt = S_PURGE;
            end
          end
          OP_TICK: begin
            time_nxt  = t_inc;
            state_nxt = S_PURGE;
            if (!d_hb[TIME_W-1]) begin
              nhb_nxt    = t_inc + TIME_W'(heartbeat_ticks);
              hb_idx_nxt = '0;
              if (cnt_r != '0) begin
                state_nxt = S_HB;
              end
            end
          end
          default: state_nxt = S_PURGE;
        endcase
      end
      S_APPEND: begin
        if (cmd_r.op == OP_REFRESH || out_free) begin
          wr_en     = 1'b1;
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = S_PURGE;
          if (cmd_r.op != OP_REFRESH) begin
            out_vld_nxt  = 1'b1;
            out_kind_nxt = (cmd_r.op == OP_FORWARD) ? K_FORWARD : K_INVALID;
            out_id_nxt   = cmd_r.id;
            out_last_nxt = 1'b1;
          end
        end
      end
      S_HB: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_kind_nxt = K_HBEAT;
          out_id_nxt   = ids_r[hb_idx_r];
          out_last_nxt = hb_last;
          hb_idx_nxt   = hb_idx_r + IDX_W'(1);
          if (hb_last) begin
            state_nxt = S_PURGE;
          end
        end
      end
      S_PURGE: begin
        if (head_expired) begin
          rm_en   = 1'b1;
          cnt_nxt = cnt_m1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    for (int i = 0; i < MAX_WORKERS; i++) begin
      ids_nxt[i] = ids_r[i];
      exp_nxt[i] = exp_r[i];
      if (rm_en && IDX_W'(i) >= rm_pos && i < MAX_WORKERS - 1) begin
        ids_nxt[i] = ids_r[(i + 1) % MAX_WORKERS];
        exp_nxt[i] = exp_r[(i + 1) % MAX_WORKERS];
      end
      if (wr_en && cnt_r == CNT_W'(i)) begin
        ids_nxt[i] = cmd_r.id;
        exp_nxt[i] = time_r + TIME_W'(expiry_ticks);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      time_r    <= '0;
      nhb_r     <= TIME_W'(HB_RST);
      hb_idx_r  <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      time_r    <= time_nxt;
      nhb_r     <= nhb_nxt;
      hb_idx_r  <= hb_idx_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_last_r <= out_last_nxt;
    for (int i = 0; i < MAX_WORKERS; i++) begin
      ids_r[i] <= ids_nxt[i];
      exp_r[i] <= exp_nxt[i];
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = 16'(out_id_r);
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

// File: sim/worker_queue_checker.sv
// Result checker for the worker liveness LRU queue: keeps its own worker table,
// expiry times and heartbeat schedule, and compares every result item in order.
// Depends on wlq_pkg; defines wlq_tb_pkg, which the testbench top also imports.
package wlq_tb_pkg;

  typedef enum logic [1:0] {
    FN_WORKER  = 2'd0,
    FN_REQUEST = 2'd1,
    FN_TICK    = 2'd2,
    FN_UNUSED  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    KIND_ASSIGNED  = 3'd0,
    KIND_HEARTBEAT = 3'd1,
    KIND_FORWARD   = 3'd2,
    KIND_INVALID   = 3'd3,
    KIND_NO_WORKER = 3'd4,
    KIND_FULL      = 3'd5
  } kind_e;

  localparam logic [7:0] CTRL_READY     = 8'd1;
  localparam logic [7:0] CTRL_HEARTBEAT = 8'd2;

  localparam logic [2:0] ADDR_EXPIRY    = 3'd0;
  localparam logic [2:0] ADDR_HEARTBEAT = 3'd4;

  localparam int HEARTBEAT_LIMIT = 16;

endpackage

module worker_queue_checker
  import wlq_pkg::*;
  import wlq_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // worker_id[15:0], control_byte[23:16]
  input  logic [2:0]  in_tuser,   // func[1:0], single_frame[2]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // worker_id_res[15:0]
  input  logic [2:0]  out_tuser,  // kind[2:0]
  input  logic        out_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    kind_e           kind;
    logic [ID_W-1:0] id;
    logic            last;
  } result_t;

  result_t            awaited_results[$];
  logic [ID_W-1:0]    worker_ids [MAX_WORKERS];
  logic [TIME_W-1:0]  worker_expiry [MAX_WORKERS];
  int                 live_count;
  logic [TIME_W-1:0]  now_t;
  logic [TIME_W-1:0]  heartbeat_due;
  logic [TICKS_W-1:0] expiry_ticks;
  logic [TICKS_W-1:0] heartbeat_ticks;

  function automatic bit reached(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] diff;
    diff = a - b;
    return !diff[TIME_W-1];
  endfunction

  task automatic drop_worker(input int pos);
    for (int i = pos; i + 1 < live_count; i++) begin
      worker_ids[i]    = worker_ids[i + 1];
      worker_expiry[i] = worker_expiry[i + 1];
    end
    if (live_count > 0) live_count--;
  endtask

  task automatic apply_item(input func_e fn, input logic [ID_W-1:0] wid, input logic single,
                            input logic [7:0] ctrl);
    result_t batch[$];
    int      pos;
    pos = -1;
    case (fn)
      FN_WORKER: begin
        for (int i = 0; i < live_count; i++)
          if (pos < 0 && worker_ids[i] == wid) pos = i;
        if (pos >= 0) drop_worker(pos);
        if (pos < 0 && live_count >= MAX_WORKERS) begin
          batch.push_back(result_t'{KIND_FULL, wid, 1'b0});
        end else begin
          worker_ids[live_count]    = wid;
          worker_expiry[live_count] = now_t + TIME_W'(expiry_ticks);
          live_count++;
          if (!single)
            batch.push_back(result_t'{KIND_FORWARD, wid, 1'b0});
          else if (ctrl != CTRL_READY && ctrl != CTRL_HEARTBEAT)
            batch.push_back(result_t'{KIND_INVALID, wid, 1'b0});
        end
      end
      FN_REQUEST: begin
        if (live_count == 0) begin
          batch.push_back(result_t'{KIND_NO_WORKER, '0, 1'b0});
        end else begin
          batch.push_back(result_t'{KIND_ASSIGNED, worker_ids[0], 1'b0});
          drop_worker(0);
        end
      end
      FN_TICK: begin
        now_t = now_t + 1'b1;
        if (reached(now_t, heartbeat_due)) begin
          for (int i = 0; i < live_count && i < HEARTBEAT_LIMIT; i++)
            batch.push_back(result_t'{KIND_HEARTBEAT, worker_ids[i], 1'b0});
          heartbeat_due = now_t + TIME_W'(heartbeat_ticks);
        end
      end
      default: ;
    endcase
    // drop expired workers from the head
    while (live_count > 0 && reached(now_t, worker_expiry[0]))
      drop_worker(0);
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[k]) awaited_results.push_back(batch[k]);
  endtask

  task automatic check_result(input logic [2:0] kind, input logic [ID_W-1:0] id,
                              input logic last);
    result_t want;
    if (awaited_results.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected result: kind %0d id %h last %b", kind, id, last);
    end else begin
      want = awaited_results.pop_front();
      if (want.kind !== kind || want.id !== id || want.last !== last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected kind %0d id %h last %b, got kind %0d id %h last %b",
                   want.kind, want.id, want.last, kind, id, last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      awaited_results.delete();
      live_count      = 0;
      now_t           = '0;
      heartbeat_due   = TIME_W'(HB_RST);
      expiry_ticks    = EXPIRY_RST;
      heartbeat_ticks = HB_RST;
      errors          = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          ADDR_EXPIRY:    expiry_ticks    = pwdata[TICKS_W-1:0];
          ADDR_HEARTBEAT: heartbeat_ticks = pwdata[TICKS_W-1:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready)
        check_result(out_tuser, out_tdata, out_tlast);
      if (in_tvalid && in_tready)
        apply_item(func_e'(in_tuser[1:0]), in_tdata[15:0], in_tuser[2], in_tdata[23:16]);
    end
    pending = awaited_results.size();
  end

endmodule

// File: sim/worker_liveness_lru_queue_tb.sv
// Testbench top for the worker liveness LRU queue: clock, reset, register writes,
// directed and random worker/request/tick items, random back-pressure and the verdict.
// Depends on wlq_pkg, wlq_tb_pkg and worker_queue_checker.
module worker_liveness_lru_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wlq_pkg::*;
  import wlq_tb_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 64;
  localparam int POOL_SIZE    = 24;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // worker_id[15:0], control_byte[23:16]
  logic [2:0]  in_tuser;   // func[1:0], single_frame[2]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;  // worker_id_res[15:0]
  logic [2:0]  out_tuser;  // kind[2:0]
  logic        out_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          errors;
  int          pending;
  int unsigned cycles = 0;
  int          idle_pct;
  int          stall_pct;
  logic [15:0] id_pool [POOL_SIZE];

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  worker_liveness_lru_queue i_dut (.*);

  worker_queue_checker i_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk)
    out_tready = ($urandom_range(0, 99) >= stall_pct);

  task automatic send_item(input func_e fn, input logic [15:0] wid, input logic single,
                           input logic [7:0] ctrl);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {ctrl, wid};
    in_tuser  = {single, fn};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [15:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = {16'h0000, value};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic settle();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic configure(input logic [15:0] expiry, input logic [15:0] heartbeat);
    settle();
    write_reg(ADDR_EXPIRY, expiry);
    write_reg(ADDR_HEARTBEAT, heartbeat);
  endtask

  task automatic run_phase(input int n_items, input int req_pct);
    int          done_items;
    int          r;
    logic [7:0]  ctrl;
    done_items = 0;
    foreach (id_pool[k])
      id_pool[k] = (k == 0) ? 16'h0000 : (k == 1) ? 16'hFFFF : 16'($urandom);
    while (done_items < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_item(FN_UNUSED, 16'($urandom), 1'($urandom), 8'($urandom));
      end else begin
        done_items++;
        if (r < 3 + req_pct) begin
          send_item(FN_REQUEST, 16'($urandom), 1'($urandom), 8'($urandom));
        end else if (r < 33 + req_pct) begin
          if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(2, 12))
              send_item(FN_TICK, 16'($urandom), 1'($urandom), 8'($urandom));
          else
            send_item(FN_TICK, 16'($urandom), 1'($urandom), 8'($urandom));
        end else begin
          if ($urandom_range(0, 4) == 0)
            ctrl = 8'($urandom);
          else
            ctrl = ($urandom_range(0, 1) == 1) ? CTRL_READY : CTRL_HEARTBEAT;
          send_item(FN_WORKER, id_pool[$urandom_range(0, POOL_SIZE - 1)],
                    ($urandom_range(0, 3) != 0), ctrl);
        end
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    idle_pct  = 0;
    stall_pct = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // request on empty table, unused func, valid and invalid control frames
    send_item(FN_REQUEST, 16'hFFFF, 1'b1, 8'hFF);
    send_item(FN_UNUSED, 16'hA5A5, 1'b1, 8'h5A);
    send_item(FN_WORKER, 16'h0000, 1'b1, CTRL_READY);
    send_item(FN_WORKER, 16'hFFFF, 1'b1, CTRL_HEARTBEAT);
    send_item(FN_WORKER, 16'h1234, 1'b1, 8'h00);
    send_item(FN_WORKER, 16'h1234, 1'b1, 8'hFF);
    send_item(FN_WORKER, 16'h5678, 1'b0, 8'hAA);
    send_item(FN_WORKER, 16'h0000, 1'b0, CTRL_READY);
    send_item(FN_REQUEST, 16'h0000, 1'b0, 8'h00);
    // fill the table, then hit it with a new id and a known id
    for (int k = 0; k < MAX_WORKERS - 3; k++)
      send_item(FN_WORKER, 16'h8000 | 16'(k), 1'b1, CTRL_READY);
    send_item(FN_WORKER, 16'h7FFF, 1'b1, CTRL_READY);
    send_item(FN_WORKER, 16'h1234, 1'b0, CTRL_READY);

    // advance to the first heartbeat round with a full table
    configure(16'd1, 16'd1);
    for (int k = 0; k < 1000; k++)
      send_item(FN_TICK, 16'($urandom), 1'($urandom), 8'($urandom));
    run_phase(42, 20);

    configure(16'd0, 16'd0);
    idle_pct  = 14;
    stall_pct = 14;
    run_phase(42, 20);

    configure(16'd20, 16'd7);
    idle_pct  = 80;
    stall_pct = 0;
    run_phase(42, 15);

    configure(16'd9, 16'd3);
    idle_pct  = 0;
    stall_pct = 80;
    run_phase(42, 20);

    configure(16'hFFFF, 16'hFFFF);
    idle_pct  = 14;
    stall_pct = 14;
    run_phase(42, 5);

    settle();
    if (errors == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
